FILE: src/ors_pkg.sv
// Shared types and constants for the 1-Wire ROM search engine.
// No dependencies; imported by every other file of the block except ors_queue.
package ors_pkg;

	// Function codes of an incoming word
	localparam logic [1:0] FUNC_BEGIN   = 2'd0;
	localparam logic [1:0] FUNC_TRIPLET = 2'd1;
	localparam logic [1:0] FUNC_RESET   = 2'd2;
	localparam logic [1:0] FUNC_FAMILY  = 2'd3;

	localparam logic [6:0] ROM_BITS      = 7'd64;
	localparam logic [6:0] FAMILY_LIMIT  = 7'd9;
	localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

	// Default queue depths (at least 2)
	localparam int CMD_DEPTH_DEF = 2;
	localparam int RES_DEPTH_DEF = 2;

	typedef enum logic [2:0] {
		ST_CONTINUE = 3'd0,
		ST_FOUND    = 3'd1,
		ST_NODEV    = 3'd2,
		ST_BUSERR   = 3'd3,
		ST_ZEROFAM  = 3'd4,
		ST_CRCFAIL  = 3'd5,
		ST_DONE     = 3'd6,
		ST_IGNORED  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		OP_BEGIN,
		OP_TRIPLET,
		OP_RESET,
		OP_FAMILY
	} op_t;

	typedef struct packed {
		logic [1:0] func;
		logic       presence;
		logic       id_bit;
		logic       inv_bit;
		logic       taken_direction;
		logic       short_detected;
		logic [7:0] target_family;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic        next_direction;
		logic [6:0]  bit_index;
		logic [63:0] rom_id;
		logic        last_device;
		logic [6:0]  family_discrepancy;
	} result_t;

	// Classified command handed from front to back
	typedef struct packed {
		op_t        op;
		logic       presence;
		logic       bus_fault;
		logic       zero_branch;
		logic       dir;
		logic [7:0] family;
	} cmd_t;

endpackage

FILE: src/ors_queue.sv
// Small synchronous FIFO with registered storage, used between stages.
// Depends on nothing; width and depth come in as parameters.
module ors_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CAP  = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CAP);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

FILE: src/ors_front.sv
// Front end: decodes an incoming word into a classified command.
// Depends on ors_pkg.
module ors_front import ors_pkg::*; (
	input  item_t item,
	output cmd_t  cmd
);
	// function decode and triplet classification
	always_comb begin
		case (item.func)
			FUNC_BEGIN:   cmd.op = OP_BEGIN;
			FUNC_TRIPLET: cmd.op = OP_TRIPLET;
			FUNC_RESET:   cmd.op = OP_RESET;
			FUNC_FAMILY:  cmd.op = OP_FAMILY;
			default:      cmd.op = OP_RESET;
		endcase
		cmd.presence    = item.presence;
		cmd.bus_fault   = (item.id_bit && item.inv_bit) || item.short_detected;
		cmd.zero_branch = !item.id_bit && !item.inv_bit && !item.taken_direction;
		cmd.dir         = item.taken_direction;
		cmd.family      = item.target_family;
	end
endmodule

FILE: src/ors_back.sv
// Back end: search state, bit-serial CRC-8 and result formation.
// Depends on ors_pkg; one command retired per cycle when the result queue has room.
module ors_back import ors_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_valid,
	output logic    cmd_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res
);
	logic [63:0] rom_q, rom_d;
	logic [6:0]  ld_q, ld_d;
	logic [6:0]  fd_q, fd_d;
	logic        ldf_q, ldf_d;
	logic [6:0]  bc_q, bc_d;
	logic [6:0]  lz_q, lz_d;
	logic        act_q, act_d;
	logic [7:0]  crc_q, crc_d;
	logic        go;
	logic [5:0]  sh;
	logic        fb;
	logic [6:0]  bc_inc;

	assign go       = cmd_valid && !res_full;
	assign cmd_pop  = go;
	assign res_push = go;
	assign sh       = 6'(bc_q - 7'd1);
	assign bc_inc   = bc_q + 7'd1;
	assign fb       = crc_q[0] ^ cmd.dir;

	// branch direction for a bit position, from the old image
	function automatic logic pick_dir(input logic [6:0] pos, input logic [6:0] ld,
	                                  input logic [63:0] rom);
		logic [5:0] i;
		i = 6'(pos - 7'd1);
		if (pos < ld) begin
			return rom[i];
		end
		return (pos == ld);
	endfunction

	// next state and result
	always_comb begin
		rom_d = rom_q; ld_d = ld_q; fd_d = fd_q; ldf_d = ldf_q;
		bc_d = bc_q; lz_d = lz_q; act_d = act_q; crc_d = crc_q;
		res.status         = ST_IGNORED;
		res.next_direction = 1'b0;
		res.bit_index      = '0;
		case (cmd.op)
			OP_RESET: begin
				rom_d = '0; ld_d = '0; fd_d = '0; ldf_d = 1'b0; act_d = 1'b0;
				res.status = ST_DONE;
			end
			OP_FAMILY: begin
				rom_d = {56'd0, cmd.family}; ld_d = ROM_BITS; fd_d = '0;
				ldf_d = 1'b0; act_d = 1'b0;
				res.status = ST_DONE;
			end
			OP_BEGIN: begin
				if (ldf_q || !cmd.presence) begin
					res.status = ST_NODEV;
				end else begin
					act_d = 1'b1; bc_d = 7'd1; lz_d = '0; crc_d = '0;
					res.status         = ST_CONTINUE;
					res.next_direction = pick_dir(7'd1, ld_q, rom_q);
					res.bit_index      = 7'd1;
				end
			end
			OP_TRIPLET: begin
				if (!act_q) begin
					res.status = ST_IGNORED;
				end else if (cmd.bus_fault) begin
					rom_d = '0; ld_d = '0; fd_d = '0; ldf_d = 1'b0; act_d = 1'b0;
					res.status = ST_BUSERR;
				end else begin
					if (cmd.zero_branch) begin
						lz_d = bc_q;
						if (bc_q < FAMILY_LIMIT) begin
							fd_d = bc_q;
						end
					end
					rom_d[sh] = cmd.dir;
					crc_d = {1'b0, crc_q[7:1]} ^ (fb ? CRC_POLY_REFL : 8'h00);
					bc_d  = bc_inc;
					if (bc_inc <= ROM_BITS) begin
						res.status         = ST_CONTINUE;
						res.next_direction = pick_dir(bc_inc, ld_q, rom_q);
						res.bit_index      = bc_inc;
					end else begin
						act_d = 1'b0;
						ld_d  = lz_d;
						if (lz_d == '0) begin
							ldf_d = 1'b1;
						end
						if (rom_d[7:0] == 8'h00) begin
							rom_d = '0; ld_d = '0; fd_d = '0; ldf_d = 1'b0;
							res.status = ST_ZEROFAM;
						end else if (crc_d != 8'h00) begin
							res.status = ST_CRCFAIL;
						end else begin
							res.status = ST_FOUND;
						end
					end
				end
			end
			default: begin
				res.status = ST_IGNORED;
			end
		endcase
		res.rom_id             = rom_d;
		res.last_device        = ldf_d;
		res.family_discrepancy = fd_d;
	end

	// search state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_q <= '0; ld_q <= '0; fd_q <= '0; ldf_q <= 1'b0;
			bc_q <= 7'd1; lz_q <= '0; act_q <= 1'b0; crc_q <= '0;
		end else if (go) begin
			rom_q <= rom_d; ld_q <= ld_d; fd_q <= fd_d; ldf_q <= ldf_d;
			bc_q <= bc_d; lz_q <= lz_d; act_q <= act_d; crc_q <= crc_d;
		end
	end
endmodule

FILE: src/onewire_rom_search_engine.sv
// 1-Wire ROM search engine top level: front decode, command queue, back end, result queue.
// A pushed word is registered in the command queue, and its result is then registered in the result queue (empty low).
// Throughput: one word per cycle while the result queue has room; the back end retires one command per cycle then.
// Reset (arst_n low, asynchronous): both queues empty, search state cleared, bit counter 1.
// Depends on ors_pkg, ors_front, ors_queue and ors_back.
module onewire_rom_search_engine import ors_pkg::*; #(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF,
	parameter int RES_DEPTH = RES_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	input  logic    pop,
	output logic    empty,
	output result_t result
);
	cmd_t    cmd_in, cmd_out;
	logic    cmd_empty, cmd_pop;
	logic    res_full, res_push;
	result_t res_in;

	ors_front u_front (
		.item (item),
		.cmd  (cmd_in)
	);

	// command queue between front and back
	ors_queue #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_out),
		.empty (cmd_empty)
	);

	ors_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_out),
		.cmd_valid(!cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	// result queue toward the consumer
	ors_queue #(.WIDTH($bits(result_t)), .DEPTH(RES_DEPTH)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);
endmodule

FILE: src/ors_checker.sv
// Port-level checks for the ROM search engine, bound to the top level.
// Depends on ors_pkg.
module ors_checker import ors_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    full,
	input logic    empty,
	input result_t result
);
	// queues come out of reset empty
	a_reset_empty: assert property (@(posedge clk)
		!$past(arst_n) |-> empty && !full)
		else $error("queues not empty after reset");

	// a continue word points at a bit position in range
	a_cont_index: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == ST_CONTINUE |->
			result.bit_index != 7'd0 && result.bit_index <= ROM_BITS)
		else $error("continue word with bad bit index");

	// only a continue word carries a direction and index
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status != ST_CONTINUE |->
			result.bit_index == 7'd0 && !result.next_direction)
		else $error("non-continue word carries direction");

	// a found ROM never has a zero family byte
	a_found_family: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == ST_FOUND |-> result.rom_id[7:0] != 8'h00)
		else $error("found ROM with zero family");

	// family discrepancy stays within the family byte
	a_fam_disc: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.family_discrepancy < FAMILY_LIMIT)
		else $error("family discrepancy out of range");
endmodule

bind onewire_rom_search_engine ors_checker u_ors_checker (.*);
